// ===== design/sht_pkg.sv =====
`default_nettype none

package sht_pkg;

   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 16;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COUNT  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd4;

   localparam logic [7:0]  SCREEN_COUNT_RST  = 8'd2;
   localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd800;
   localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd480;
   localparam logic [15:0] FRAME_WIDTH_RST   = 16'd800;
   localparam logic [15:0] FRAME_HEIGHT_RST  = 16'd960;

   localparam logic [31:0] HANDLE_START = 32'h0001_0000;

   // commands
   localparam logic [3:0] CMD_COUNT    = 4'd0;
   localparam logic [3:0] CMD_FBSIZE   = 4'd1;
   localparam logic [3:0] CMD_SCREEN   = 4'd2;
   localparam logic [3:0] CMD_REQ_FLIP = 4'd3;
   localparam logic [3:0] CMD_FLIP     = 4'd4;
   localparam logic [3:0] CMD_CREATE   = 4'd5;
   localparam logic [3:0] CMD_DESTROY  = 4'd6;
   localparam logic [3:0] CMD_QUERY    = 4'd8;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

   typedef struct packed {
      logic [3:0]         command;
      logic [31:0]        usage_word;
      logic signed [31:0] req_width;
      logic signed [31:0] req_height;
      logic [31:0]        handle_in;
      logic signed [31:0] screen_index;
   } sht_req_type;

   typedef struct packed {
      logic [7:0]  count_out;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [31:0] out_width;
      logic [31:0] out_height;
      logic [31:0] handle_out;
      logic [31:0] stride_out;
      logic [31:0] usage_out;
      logic        flip_result;
      logic [1:0]  status;
   } sht_rsp_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic scan_step;
      logic finish;
   } sht_ctl_type;

   typedef struct packed {
      logic clear_last;
      logic req_scan;
      logic scan_end;
      logic out_free;
   } sht_sts_type;

endpackage

`default_nettype wire

// ===== design/surface_handle_table_core.sv =====
// surface handle table: one response for each request
//
// request channel (req_valid / req_stall / req_data) carries a command and its
// arguments; response channel (rsp_valid / rsp_stall / rsp_data) returns one
// result record per request, in order. csr_wr_en / csr_index / csr_wr_data
// write the screen and framebuffer registers; write only while idle.
// count, fbsize, screen, flip and no-op commands go from accept straight to the
// done state, which registers the response. create, destroy and query walk the
// slot table one entry per cycle through the handle memory read port, ending at
// the first matching slot or after the last entry, before the done state.
// one request is in flight at a time; req_stall stays high from accept until its
// response is registered.
// after reset the handle memory is swept to zero, one entry per cycle, over all
// TABLE_ENTRIES slots, with req_stall high; csr writes are taken throughout.
// a stalled response holds in the output register; a finished request waits
// for it to drain before it is loaded, and no new request is taken meanwhile.
`default_nettype none

module surface_handle_table_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire sht_pkg::sht_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output sht_pkg::sht_rsp_type                rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [sht_pkg::CFG_IDX_W-1:0]  csr_index,
   input  wire logic [sht_pkg::CFG_DATA_W-1:0] csr_wr_data
);

   import sht_pkg::*;

   sht_ctl_type ctl;
   sht_sts_type sts;

   sht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   sht_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule

`default_nettype wire

// ===== design/sht_ram.sv =====
`default_nettype none

module sht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sht_ctrl.sv =====
`default_nettype none

module sht_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sht_pkg::sht_sts_type sts,
   output sht_pkg::sht_ctl_type      ctl
);

   import sht_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = sts.req_scan ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (sts.out_free) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sht_datapath.sv =====
`default_nettype none

module sht_datapath #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sht_pkg::sht_req_type                req_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [sht_pkg::CFG_IDX_W-1:0]       csr_index,
   input  wire logic [sht_pkg::CFG_DATA_W-1:0]      csr_wr_data,
   input  wire sht_pkg::sht_ctl_type                ctl,
   output sht_pkg::sht_sts_type                     sts,
   output logic                                     rsp_valid,
   output sht_pkg::sht_rsp_type                     rsp_data,
   input  wire logic                                rsp_stall
);

   import sht_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   // configuration
   logic [7:0]  screen_count_ff;
   logic [15:0] screen_width_ff;
   logic [15:0] screen_height_ff;
   logic [15:0] frame_width_ff;
   logic [15:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_count_ff  <= SCREEN_COUNT_RST;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_SCREEN_COUNT:  screen_count_ff  <= csr_wr_data[7:0];
            CFG_SCREEN_WIDTH:  screen_width_ff  <= csr_wr_data;
            CFG_SCREEN_HEIGHT: screen_height_ff <= csr_wr_data;
            CFG_FRAME_WIDTH:   frame_width_ff   <= csr_wr_data;
            CFG_FRAME_HEIGHT:  frame_height_ff  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // request register and scan state
   sht_req_type req_ff;
   logic [31:0] next_handle_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_addr_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [31:0]      fnd_usage_ff;
   logic [31:0]      fnd_width_ff;
   logic [31:0]      fnd_height_ff;

   logic [31:0] rd_handle;
   logic [95:0] rd_rec;
   logic        is_create;
   logic        match;
   logic        issue;

   assign is_create = (req_ff.command == CMD_CREATE);
   assign match = chk_vld_ff && (is_create ? (rd_handle == 32'd0)
                                           : ((rd_handle == req_ff.handle_in) &&
                                              (req_ff.handle_in != 32'd0)));
   assign issue = ctl.scan_step && (cnt_ff < CNT_END);

   assign sts.clear_last = (cnt_ff == CNT_LAST);
   assign sts.req_scan   = (req_data.command == CMD_CREATE) ||
                           (req_data.command == CMD_DESTROY) ||
                           (req_data.command == CMD_QUERY);
   assign sts.scan_end   = match || (chk_vld_ff && (chk_addr_ff == IDX_LAST));
   assign sts.out_free   = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         chk_vld_ff     <= 1'b0;
         next_handle_ff <= HANDLE_START;
      end else begin
         if (ctl.clear_step || issue) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (ctl.load) begin
            cnt_ff     <= '0;
            chk_vld_ff <= 1'b0;
         end else begin
            chk_vld_ff <= issue;
         end
         if (ctl.finish && is_create && hit_ff) begin
            next_handle_ff <= next_handle_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
         hit_ff <= 1'b0;
      end
      if (issue) begin
         chk_addr_ff <= cnt_ff[IDX_W-1:0];
      end
      if (ctl.scan_step && sts.scan_end) begin
         hit_ff        <= match;
         slot_ff       <= chk_addr_ff;
         fnd_usage_ff  <= rd_rec[95:64];
         fnd_width_ff  <= rd_rec[63:32];
         fnd_height_ff <= rd_rec[31:0];
      end
   end

   // table storage: handles are swept to zero after reset
   logic             hnd_we;
   logic [IDX_W-1:0] hnd_waddr;
   logic [31:0]      hnd_wdata;
   logic             rec_we;

   always_comb begin
      hnd_we    = 1'b0;
      hnd_waddr = slot_ff;
      hnd_wdata = 32'd0;
      if (ctl.clear_step) begin
         hnd_we    = 1'b1;
         hnd_waddr = cnt_ff[IDX_W-1:0];
      end else if (ctl.finish && hit_ff) begin
         if (is_create) begin
            hnd_we    = 1'b1;
            hnd_wdata = next_handle_ff;
         end else if (req_ff.command == CMD_DESTROY) begin
            hnd_we = 1'b1;
         end
      end
   end

   assign rec_we = ctl.finish && hit_ff && is_create;

   sht_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_ENTRIES),
      .AW    (IDX_W)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (hnd_we),
      .wr_addr (hnd_waddr),
      .wr_data (hnd_wdata),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_handle)
   );

   sht_ram #(
      .WIDTH (96),
      .DEPTH (TABLE_ENTRIES),
      .AW    (IDX_W)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (slot_ff),
      .wr_data ({req_ff.usage_word, req_ff.req_width, req_ff.req_height}),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_rec)
   );

   // result build
   sht_rsp_type rsp_in;
   sht_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      case (req_ff.command)
         CMD_COUNT: begin
            rsp_in.count_out = screen_count_ff;
         end
         CMD_FBSIZE: begin
            rsp_in.out_width  = {16'd0, frame_width_ff};
            rsp_in.out_height = {16'd0, frame_height_ff};
         end
         CMD_SCREEN: begin
            rsp_in.pos_y      = (req_ff.screen_index == 32'sd0) ? 16'd0 : screen_height_ff;
            rsp_in.out_width  = {16'd0, screen_width_ff};
            rsp_in.out_height = {16'd0, screen_height_ff};
         end
         CMD_REQ_FLIP: begin
            rsp_in.flip_result = 1'b1;
         end
         CMD_CREATE: begin
            if (hit_ff) begin
               rsp_in.handle_out = next_handle_ff;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         CMD_QUERY: begin
            if (hit_ff) begin
               rsp_in.out_width  = fnd_width_ff;
               rsp_in.out_height = fnd_height_ff;
               rsp_in.stride_out = {fnd_width_ff[29:0], 2'b00};
               rsp_in.usage_out  = fnd_usage_ff;
            end else begin
               rsp_in.status = ST_BAD_HANDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
